[design/btlv_pkg.sv]
// Shared types and constants for the BER TLV stream decoder.
// No dependencies; every other design file imports this package.
package btlv_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 4;
  localparam int LEN_W                = 32;
  localparam logic [7:0] SHORT_LIMIT  = 8'd128;
  localparam logic [6:0] COUNT_MASK   = 7'h7F;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN1 = 2'd1,
    PH_LENX = 2'd2,
    PH_VAL  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TAG     = 3'd0,
    KIND_LEN     = 3'd1,
    KIND_VAL     = 3'd2,
    KIND_TRUNC   = 3'd3,
    KIND_TOOLONG = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } byte_item_t;

  typedef struct packed {
    kind_t            byte_kind;
    logic [7:0]       element_tag;
    logic [LEN_W-1:0] element_length;
    logic [7:0]       value_byte;
    logic             element_done;
  } result_t;

endpackage

[design/btlv_byte_if.sv]
// Byte channel into the decoder: valid/ready handshake plus one encoded byte.
// Depends on btlv_pkg.
interface btlv_byte_if import btlv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[design/btlv_res_if.sv]
// Result channel out of the decoder: valid/ready handshake plus one classified byte.
// Depends on btlv_pkg.
interface btlv_res_if import btlv_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_t            byte_kind;
  logic [7:0]       element_tag;
  logic [LEN_W-1:0] element_length;
  logic [7:0]       value_byte;
  logic             element_done;

  modport source (output valid, output byte_kind, output element_tag,
                  output element_length, output value_byte, output element_done,
                  input ready);
  modport sink   (input valid, input byte_kind, input element_tag,
                  input element_length, input value_byte, input element_done,
                  output ready);
endinterface

[design/btlv_in_reg.sv]
// Input register stage: holds one accepted byte until the decode step takes it.
// Depends on btlv_pkg.
module btlv_in_reg import btlv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  input  byte_item_t load_item,
  output logic       load_ready,
  input  logic       advance,
  output logic       valid,
  output byte_item_t item
);

  assign load_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      item <= load_item;
    end
  end

endmodule

[design/btlv_core.sv]
// Decode step: TLV parser state and the per-byte classification logic.
// Depends on btlv_pkg.
module btlv_core import btlv_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  byte_item_t item,
  output result_t    result
);

  localparam int LBL_W = $clog2(MAX_LENGTH_BYTES + 1);

  phase_t           phase, phase_next;
  logic [7:0]       current_tag, current_tag_next;
  logic [LEN_W-1:0] length_accumulator, length_accumulator_next;
  logic [LBL_W-1:0] length_bytes_left, length_bytes_left_next;
  logic [LEN_W-1:0] value_bytes_left, value_bytes_left_next;

  logic [7:0]       b;
  logic             eob;
  logic [6:0]       count;
  logic [LEN_W-1:0] hdr_len;
  logic             hdr_take;
  logic [LEN_W-1:0] acc_shift;
  logic [LBL_W-1:0] lbl_dec;
  logic [LEN_W-1:0] vbl_dec;

  always_comb begin
    b         = item.data_byte;
    eob       = item.end_of_buffer;
    count     = b[6:0] & COUNT_MASK;
    acc_shift = {length_accumulator[LEN_W-9:0], b};
    lbl_dec   = (length_bytes_left != '0) ? length_bytes_left - LBL_W'(1) : length_bytes_left;
    vbl_dec   = (value_bytes_left != '0) ? value_bytes_left - LEN_W'(1) : value_bytes_left;

    phase_next              = phase;
    current_tag_next        = current_tag;
    length_accumulator_next = length_accumulator;
    length_bytes_left_next  = length_bytes_left;
    value_bytes_left_next   = value_bytes_left;
    hdr_take                = 1'b0;
    hdr_len                 = '0;

    result.byte_kind      = KIND_TAG;
    result.element_tag    = current_tag;
    result.element_length = '0;
    result.value_byte     = '0;
    result.element_done   = 1'b0;

    unique case (phase)
      PH_TAG: begin
        current_tag_next        = b;
        result.element_tag      = b;
        length_accumulator_next = '0;
        length_bytes_left_next  = '0;
        value_bytes_left_next   = '0;
        if (eob) begin
          phase_next       = PH_TAG;
          result.byte_kind = KIND_TRUNC;
        end else begin
          phase_next       = PH_LEN1;
          result.byte_kind = KIND_TAG;
        end
      end
      PH_LEN1: begin
        if (b < SHORT_LIMIT) begin
          hdr_take = 1'b1;
          hdr_len  = LEN_W'(b);
        end else begin
          length_accumulator_next = '0;
          if (count > 7'(MAX_LENGTH_BYTES)) begin
            phase_next       = PH_TAG;
            result.byte_kind = KIND_TOOLONG;
          end else if (count == '0) begin
            hdr_take = 1'b1;
          end else if (eob) begin
            phase_next       = PH_TAG;
            result.byte_kind = KIND_TRUNC;
          end else begin
            length_bytes_left_next = LBL_W'(count);
            phase_next             = PH_LENX;
            result.byte_kind       = KIND_LEN;
          end
        end
      end
      PH_LENX: begin
        length_accumulator_next = acc_shift;
        length_bytes_left_next  = lbl_dec;
        if (lbl_dec == '0) begin
          hdr_take = 1'b1;
          hdr_len  = acc_shift;
        end else if (eob) begin
          phase_next            = PH_TAG;
          result.byte_kind      = KIND_TRUNC;
          result.element_length = acc_shift;
        end else begin
          result.byte_kind = KIND_LEN;
        end
      end
      PH_VAL: begin
        value_bytes_left_next = vbl_dec;
        result.element_length = length_accumulator;
        if (vbl_dec == '0) begin
          phase_next          = PH_TAG;
          result.byte_kind    = KIND_VAL;
          result.value_byte   = b;
          result.element_done = 1'b1;
        end else if (eob) begin
          phase_next       = PH_TAG;
          result.byte_kind = KIND_TRUNC;
        end else begin
          result.byte_kind  = KIND_VAL;
          result.value_byte = b;
        end
      end
      default: begin
        phase_next = PH_TAG;
      end
    endcase

    // Header complete: finish on zero length, flag early end, or open the value.
    if (hdr_take) begin
      length_accumulator_next = hdr_len;
      result.element_length   = hdr_len;
      if (hdr_len == '0) begin
        phase_next          = PH_TAG;
        result.byte_kind    = KIND_LEN;
        result.element_done = 1'b1;
      end else if (eob) begin
        phase_next       = PH_TAG;
        result.byte_kind = KIND_TRUNC;
      end else begin
        value_bytes_left_next = hdr_len;
        phase_next            = PH_VAL;
        result.byte_kind      = KIND_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TAG;
      current_tag        <= '0;
      length_accumulator <= '0;
      length_bytes_left  <= '0;
      value_bytes_left   <= '0;
    end else if (step) begin
      phase              <= phase_next;
      current_tag        <= current_tag_next;
      length_accumulator <= length_accumulator_next;
      length_bytes_left  <= length_bytes_left_next;
      value_bytes_left   <= value_bytes_left_next;
    end
  end

endmodule

[design/btlv_out_reg.sv]
// Result register: holds one classified byte until the downstream side takes it.
// Depends on btlv_pkg.
module btlv_out_reg import btlv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    free,
  input  logic    take,
  output logic    valid,
  output result_t data
);

  assign free = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= load_data;
    end
  end

endmodule

[design/ber_tlv_stream_decoder.sv]
// Top level of the BER TLV stream decoder.
// Depends on btlv_pkg, btlv_byte_if, btlv_res_if, btlv_in_reg, btlv_core, btlv_out_reg.

// The decoder takes an encoded buffer one byte per item on stream and returns
// one result item per byte on result: the byte's role (tag, length, value,
// truncated-buffer error or too-many-length-bytes error), the current element's
// tag and decoded length, the value byte itself, and a done flag on the byte
// that closes an element. After an element closes, or after any error, the next
// byte is taken as a new tag. It sustains one byte per clock while result is not
// stalled: the parser state (phase, tag, length accumulator and remaining counts)
// updates once per byte, so items may follow back to back. A byte is taken into
// the input register; its result is computed combinationally and loaded into the
// result register, from which it is offered on result. Stalls on result back up into
// stream without losing or repeating an item, once both registers hold an item.
// MAX_LENGTH_BYTES sets how many long-form length bytes are allowed;
// the length is kept to its low 32 bits.
module ber_tlv_stream_decoder import btlv_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  btlv_byte_if.sink  stream,
  btlv_res_if.source result
);

  byte_item_t in_item;
  byte_item_t s1_item;
  logic       s1_valid;
  logic       advance;
  logic       out_free;
  result_t    step_result;
  result_t    out_data;
  logic       out_valid;

  // Pack the incoming byte.
  assign in_item.data_byte     = stream.data_byte;
  assign in_item.end_of_buffer = stream.end_of_buffer;

  // Advance the held byte whenever the result register can take its result.
  assign advance = s1_valid && out_free;

  btlv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stream.valid),
    .load_item  (in_item),
    .load_ready (stream.ready),
    .advance    (advance),
    .valid      (s1_valid),
    .item       (s1_item)
  );

  btlv_core #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .result (step_result)
  );

  btlv_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_data (step_result),
    .free      (out_free),
    .take      (result.ready),
    .valid     (out_valid),
    .data      (out_data)
  );

  // Drive the result channel from the result register.
  assign result.valid          = out_valid;
  assign result.byte_kind      = out_data.byte_kind;
  assign result.element_tag    = out_data.element_tag;
  assign result.element_length = out_data.element_length;
  assign result.value_byte     = out_data.value_byte;
  assign result.element_done   = out_data.element_done;

endmodule
